/* hdl/pv_pkg.sv */
// Package for the permutation validator: payload types, verdict codes, constants.
`default_nettype none
package pv_pkg;

  // Field widths of the request and response items
  localparam int VERTEX_W = 16;
  localparam int POS_W    = 10;
  localparam int CNT_W    = 11;
  localparam int LEN_W    = 11;
  localparam int EPOCH_W  = 8;

  localparam int              MAX_LENGTH_DEF = 1024;
  localparam logic [LEN_W-1:0] LEN_RESET     = 11'd1024;

  // Verdict codes
  localparam logic [1:0] VERDICT_OK        = 2'd0;
  localparam logic [1:0] VERDICT_MISMATCH  = 2'd1;
  localparam logic [1:0] VERDICT_RANGE     = 2'd2;
  localparam logic [1:0] VERDICT_DUPLICATE = 2'd3;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic                is_last;
  } pv_req_t;

  typedef struct packed {
    logic [1:0]          verdict;
    logic [POS_W-1:0]    bad_position;
    logic [VERTEX_W-1:0] bad_vertex;
    logic [POS_W-1:0]    earlier_position;
    logic [CNT_W-1:0]    received_count;
  } pv_rsp_t;

  // Seen table mode: clearing sweep or normal operation
  typedef enum logic {
    CLR_SWEEP,
    CLR_RUN
  } pv_clr_state_t;

endpackage
`default_nettype wire

/* hdl/pv_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module pv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* hdl/pv_outq.sv */
// Two-entry response queue between the check stage and the output channel.
`default_nettype none
module pv_outq
  import pv_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire pv_rsp_t push_rsp,
  output logic [1:0]   count,
  output logic         out_valid,
  input  wire logic    out_ready,
  output pv_rsp_t      out_rsp
);

  pv_rsp_t    mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign pop       = (count_r != 2'd0) && out_ready;
  assign out_valid = (count_r != 2'd0);
  assign out_rsp   = mem_r[rd_ptr_r];
  assign count     = count_r;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold response payloads
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rsp;
    end
  end

endmodule
`default_nettype wire

/* hdl/pv_check.sv */
// Check stage: seen table in RAM with epoch tags, forwarding, error tracking, clearing sweep.
`default_nettype none
module pv_check
  import pv_pkg::*;
#(
  parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [LEN_W-1:0] perm_length,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire pv_req_t          in_req,
  input  wire logic [1:0]       q_count,
  output logic                  rsp_push,
  output pv_rsp_t               rsp
);

  localparam int AW = $clog2(MAX_LENGTH);
  localparam int CW = $clog2(MAX_LENGTH + 2);
  localparam int DW = EPOCH_W + AW;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_LENGTH - 1);
  localparam logic [CW-1:0] CNT_SAT   = CW'(MAX_LENGTH + 1);

  pv_clr_state_t        state_r, state_nxt;
  logic [AW-1:0]        sweep_addr_r, sweep_addr_nxt;
  logic [EPOCH_W-1:0]   epoch_r, epoch_nxt;
  logic                 s1_valid_r;
  logic [VERTEX_W-1:0]  s1_vertex_r;
  logic                 s1_last_r;
  logic [CW-1:0]        count_r, count_nxt, count_inc;
  logic [1:0]           err_code_r, err_code_nxt;
  logic [AW-1:0]        err_pos_r, err_pos_nxt;
  logic [VERTEX_W-1:0]  err_vertex_r, err_vertex_nxt;
  logic [AW-1:0]        err_earlier_r, err_earlier_nxt;
  logic                 fwd_valid_r, fwd_valid_nxt;
  logic [AW-1:0]        fwd_addr_r, fwd_addr_nxt;
  logic [AW-1:0]        fwd_pos_r, fwd_pos_nxt;

  logic                 accept;
  logic                 wrap_pending;
  logic                 room;
  logic [CW-1:0]        n_eff;
  logic [AW-1:0]        s1_addr;
  logic [AW-1:0]        pos;
  logic [DW-1:0]        rdata;
  logic [EPOCH_W-1:0]   rd_epoch;
  logic [AW-1:0]        rd_pos;
  logic                 fwd_hit;
  logic                 seen;
  logic [AW-1:0]        earlier;
  logic                 in_window;
  logic                 out_of_range;
  logic                 wr_seq;
  logic                 mismatch;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [DW-1:0]        ram_wdata;

  // Effective length, clamped to the table depth
  assign n_eff = ({21'd0, perm_length} > 32'(MAX_LENGTH)) ? CW'(MAX_LENGTH) : CW'(perm_length);

  // Accept a request when running, no epoch wrap is due and a response slot is free
  assign wrap_pending = s1_valid_r && s1_last_r && (epoch_r == '1);
  assign room         = (q_count == 2'd0) || ((q_count == 2'd1) && !(s1_valid_r && s1_last_r));
  assign in_ready     = (state_r == CLR_RUN) && !wrap_pending && room;
  assign accept       = in_valid && in_ready;

  // Seen table: {epoch, position} per index
  pv_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_LENGTH)
  ) u_seen_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_req.vertex[AW-1:0]),
    .rdata (rdata)
  );

  assign rd_epoch = rdata[DW-1:AW];
  assign rd_pos   = rdata[AW-1:0];
  assign s1_addr  = s1_vertex_r[AW-1:0];
  assign pos      = count_r[AW-1:0];

  // Forward the previous cycle's write of the same sequence
  assign fwd_hit  = fwd_valid_r && (fwd_addr_r == s1_addr);
  assign seen     = fwd_hit || (rd_epoch == epoch_r);
  assign earlier  = fwd_hit ? fwd_pos_r : rd_pos;

  assign in_window    = (32'(count_r) < 32'(MAX_LENGTH)) && (err_code_r == VERDICT_OK);
  assign out_of_range = 32'(s1_vertex_r) >= 32'(n_eff);
  assign count_inc    = (count_r < CNT_SAT) ? count_r + CW'(1) : count_r;

  // Check the element in stage 1 and record the first error
  always_comb begin
    err_code_nxt    = err_code_r;
    err_pos_nxt     = err_pos_r;
    err_vertex_nxt  = err_vertex_r;
    err_earlier_nxt = err_earlier_r;
    wr_seq          = 1'b0;
    if (s1_valid_r && in_window) begin
      if (out_of_range) begin
        err_code_nxt    = VERDICT_RANGE;
        err_pos_nxt     = pos;
        err_vertex_nxt  = s1_vertex_r;
        err_earlier_nxt = '0;
      end else if (seen) begin
        err_code_nxt    = VERDICT_DUPLICATE;
        err_pos_nxt     = pos;
        err_vertex_nxt  = s1_vertex_r;
        err_earlier_nxt = earlier;
      end else begin
        wr_seq = 1'b1;
      end
    end
  end

  // Build the response on the last element
  assign mismatch = 32'(count_inc) != 32'(n_eff);
  assign rsp_push = s1_valid_r && s1_last_r;

  always_comb begin
    rsp.received_count = CNT_W'(count_inc);
    if (mismatch) begin
      rsp.verdict          = VERDICT_MISMATCH;
      rsp.bad_position     = '0;
      rsp.bad_vertex       = '0;
      rsp.earlier_position = '0;
    end else begin
      rsp.verdict          = err_code_nxt;
      rsp.bad_position     = POS_W'(err_pos_nxt);
      rsp.bad_vertex       = err_vertex_nxt;
      rsp.earlier_position = POS_W'(err_earlier_nxt);
    end
  end

  // Sequence state, epoch and sweep control
  always_comb begin
    state_nxt      = state_r;
    sweep_addr_nxt = sweep_addr_r;
    epoch_nxt      = epoch_r;
    count_nxt      = count_r;
    ram_we         = 1'b0;
    ram_waddr      = s1_addr;
    ram_wdata      = {epoch_r, pos};
    fwd_valid_nxt  = wr_seq && !s1_last_r;
    fwd_addr_nxt   = s1_addr;
    fwd_pos_nxt    = pos;
    case (state_r)
      CLR_SWEEP: begin
        ram_we         = 1'b1;
        ram_waddr      = sweep_addr_r;
        ram_wdata      = '0;
        sweep_addr_nxt = sweep_addr_r + AW'(1);
        if (sweep_addr_r == LAST_ADDR) begin
          sweep_addr_nxt = '0;
          state_nxt      = CLR_RUN;
        end
      end
      CLR_RUN: begin
        ram_we = wr_seq;
        if (s1_valid_r) begin
          count_nxt = count_inc;
          if (s1_last_r) begin
            count_nxt = '0;
            if (epoch_r == '1) begin
              // Tags would alias: clear the table and restart at epoch one
              epoch_nxt = EPOCH_W'(1);
              state_nxt = CLR_SWEEP;
            end else begin
              epoch_nxt = epoch_r + EPOCH_W'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = CLR_SWEEP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= CLR_SWEEP;
      sweep_addr_r  <= '0;
      epoch_r       <= EPOCH_W'(1);
      s1_valid_r    <= 1'b0;
      count_r       <= '0;
      err_code_r    <= VERDICT_OK;
      err_pos_r     <= '0;
      err_vertex_r  <= '0;
      err_earlier_r <= '0;
      fwd_valid_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      epoch_r      <= epoch_nxt;
      s1_valid_r   <= accept;
      count_r      <= count_nxt;
      fwd_valid_r  <= fwd_valid_nxt;
      // Drop error state at the end of a sequence
      if (rsp_push) begin
        err_code_r    <= VERDICT_OK;
        err_pos_r     <= '0;
        err_vertex_r  <= '0;
        err_earlier_r <= '0;
      end else begin
        err_code_r    <= err_code_nxt;
        err_pos_r     <= err_pos_nxt;
        err_vertex_r  <= err_vertex_nxt;
        err_earlier_r <= err_earlier_nxt;
      end
    end
  end

  // Stage 1 payload and forwarding payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_vertex_r <= in_req.vertex;
      s1_last_r   <= in_req.is_last;
    end
    fwd_addr_r <= fwd_addr_nxt;
    fwd_pos_r  <= fwd_pos_nxt;
  end

endmodule
`default_nettype wire

/* hdl/permutation_validator.sv */
// Top level of the permutation validator: length register, check stage, response queue.
//
// Checks that a stream of indices, closed by an element with is_last set, is a
// permutation of 0..N-1, N being perm_length (clamped to MAX_LENGTH). A request can
// be taken every clock cycle while in_ready is high. The seen table is a RAM read at
// the edge that takes the request; the entry is checked in the next cycle and written
// back at the end of it, with a forwarding register covering back-to-back hits on one
// index. The verdict of a sequence enters a two-entry response queue at the edge after
// its last request is taken, and out_valid is high while the queue holds a response.
// in_ready drops while two responses wait, or while one waits and a last request is
// being checked. Table entries carry an 8-bit sequence tag instead of being cleared
// per sequence: after reset a clearing pass over every entry runs with in_ready low,
// and after every 255 sequences, when the tag wraps, the pass runs again with in_ready
// low. perm_length may be rewritten only while no sequence is in progress.
`default_nettype none
module permutation_validator
  import pv_pkg::*;
#(
  parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [LEN_W-1:0] cfg_wr_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire pv_req_t          in_req,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output pv_rsp_t               out_rsp
);

  logic [LEN_W-1:0] perm_length_r;
  logic [1:0]       q_count;
  logic             rsp_push;
  pv_rsp_t          rsp;

  // Hold the configured length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      perm_length_r <= LEN_RESET;
    end else if (cfg_wr_en) begin
      perm_length_r <= cfg_wr_data;
    end
  end

  pv_check #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .perm_length (perm_length_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req      (in_req),
    .q_count     (q_count),
    .rsp_push    (rsp_push),
    .rsp         (rsp)
  );

  pv_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rsp_push),
    .push_rsp  (rsp),
    .count     (q_count),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

endmodule
`default_nettype wire
